// ----- rtl/fac_pkg.sv -----
// shared types and constants for the frame average color block
package fac_pkg;

	localparam int DIM_W    = 13;
	localparam int POS_W    = 12;
	localparam int STRIDE_W = 8;
	localparam int CH_W     = 8;
	localparam int SUM_W    = 32;
	localparam int CNT_W    = 25;
	localparam int PIX_W    = 3 * CH_W;
	localparam int QUOT_W   = 8;
	localparam int ADDR_W   = 4;

	localparam logic [DIM_W-1:0]    MAX_DIM    = 13'd4096;
	localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd1920;
	localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd1080;
	localparam logic [STRIDE_W-1:0] STRIDE_RST = 8'd10;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STRIDE = 2'd2;

	// effective frame geometry, dimensions clamped and stride nonzero
	typedef struct packed {
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [STRIDE_W-1:0] stride;
	} fac_cfg_t;

	// sums of one finished frame, handed from the front to the divider
	typedef struct packed {
		logic [SUM_W-1:0] red_total;
		logic [SUM_W-1:0] green_total;
		logic [SUM_W-1:0] blue_total;
		logic [CNT_W-1:0] count;
		logic             stride_error;
	} fac_frame_t;

endpackage

// ----- rtl/fac_front.sv -----
// pixel front end: raster position, row sampling and channel sums
module fac_front import fac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fac_cfg_t         cfg,
	input  logic             stride_wr,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  logic [PIX_W-1:0] pix_data,
	output logic             frame_valid,
	input  logic             frame_ready,
	output fac_frame_t       frame
);

	logic [POS_W-1:0]    col_q;
	logic [POS_W-1:0]    row_q;
	logic [STRIDE_W-1:0] phase_q;
	logic [SUM_W-1:0]    red_q;
	logic [SUM_W-1:0]    green_q;
	logic [SUM_W-1:0]    blue_q;
	logic [CNT_W-1:0]    count_q;
	logic                busy_q;
	logic [3:0]          step_q;
	logic [STRIDE_W-1:0] rem_q;

	logic                accept;
	logic                sample;
	logic                row_end;
	logic                frame_end;
	logic [SUM_W-1:0]    red_nx;
	logic [SUM_W-1:0]    green_nx;
	logic [SUM_W-1:0]    blue_nx;
	logic [CNT_W-1:0]    count_nx;
	logic [STRIDE_W-1:0] phase_inc;
	logic [STRIDE_W-1:0] phase_nx;
	logic [STRIDE_W:0]   rem_shift;
	logic [STRIDE_W:0]   rem_red;

	// stall while the row phase is rebuilt or the queue is full
	assign pix_ready = !busy_q && frame_ready;
	assign accept    = pix_valid && pix_ready;

	// a row is sampled when it is a multiple of the stride and a whole stride fits below it
	assign sample = (phase_q == '0) &&
		(({2'b0, row_q} + {6'b0, cfg.stride}) <= {1'b0, cfg.height});

	assign red_nx   = red_q   + (sample ? {24'b0, pix_data[23:16]} : '0);
	assign green_nx = green_q + (sample ? {24'b0, pix_data[15:8]}  : '0);
	assign blue_nx  = blue_q  + (sample ? {24'b0, pix_data[7:0]}   : '0);
	assign count_nx = count_q + {{(CNT_W-1){1'b0}}, sample};

	// raster position
	assign row_end   = {1'b0, col_q} >= (cfg.width - 13'd1);
	assign frame_end = row_end && ({1'b0, row_q} >= (cfg.height - 13'd1));
	assign phase_inc = phase_q + 8'd1;
	assign phase_nx  = (phase_inc == cfg.stride) ? '0 : phase_inc;

	// finished frame goes to the queue on its last pixel
	assign frame_valid        = accept && frame_end;
	assign frame.red_total    = red_nx;
	assign frame.green_total  = green_nx;
	assign frame.blue_total   = blue_nx;
	assign frame.count        = count_nx;
	assign frame.stride_error = {5'b0, cfg.stride} > cfg.height;

	// one bit of row mod stride per cycle
	assign rem_shift = {rem_q, row_q[step_q]};
	assign rem_red   = (rem_shift >= {1'b0, cfg.stride}) ?
		(rem_shift - {1'b0, cfg.stride}) : rem_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			step_q  <= '0;
			rem_q   <= '0;
		end else if (stride_wr) begin
			busy_q <= 1'b1;
			step_q <= 4'd11;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_red[STRIDE_W-1:0];
			step_q <= step_q - 4'd1;
			if (step_q == 4'd0) begin
				phase_q <= rem_red[STRIDE_W-1:0];
				busy_q  <= 1'b0;
			end
		end else if (accept) begin
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				phase_q <= '0;
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
				count_q <= '0;
			end else begin
				red_q   <= red_nx;
				green_q <= green_nx;
				blue_q  <= blue_nx;
				count_q <= count_nx;
				if (row_end) begin
					col_q   <= '0;
					row_q   <= row_q + 12'd1;
					phase_q <= phase_nx;
				end else begin
					col_q <= col_q + 12'd1;
				end
			end
		end
	end

endmodule

// ----- rtl/fac_queue.sv -----
// two-entry queue of finished frame sums between front and divider
module fac_queue import fac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  fac_frame_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output fac_frame_t out_data
);

	fac_frame_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_ready  = fill_q != 2'd2;
	assign out_valid = fill_q != 2'd0;
	assign out_data  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/fac_divider.sv -----
// back end: per-channel mean by restoring division and result register
module fac_divider import fac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fac_frame_t       in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_color,
	output logic             out_error
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic              state_q;
	logic [2:0]        step_q;
	logic [SUM_W-1:0]  red_rem_q;
	logic [SUM_W-1:0]  green_rem_q;
	logic [SUM_W-1:0]  blue_rem_q;
	logic [QUOT_W-1:0] red_quot_q;
	logic [QUOT_W-1:0] green_quot_q;
	logic [QUOT_W-1:0] blue_quot_q;
	logic [CNT_W-1:0]  count_q;
	logic              error_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  color_q;
	logic              out_error_q;

	logic [SUM_W:0]    red_step;
	logic [SUM_W:0]    green_step;
	logic [SUM_W:0]    blue_step;
	logic [QUOT_W-1:0] red_quot_nx;
	logic [QUOT_W-1:0] green_quot_nx;
	logic [QUOT_W-1:0] blue_quot_nx;

	// one quotient bit: subtract count shifted by the bit weight if it fits
	function automatic logic [SUM_W:0] div_step(input logic [SUM_W-1:0] rem,
		input logic [CNT_W-1:0] cnt, input logic [2:0] step);
		logic [SUM_W-1:0] shifted;
		shifted = {7'b0, cnt} << step;
		if (rem >= shifted) begin
			div_step = {1'b1, rem - shifted};
		end else begin
			div_step = {1'b0, rem};
		end
	endfunction

	// the mean never exceeds 255, so eight quotient bits cover it
	assign red_step   = div_step(red_rem_q, count_q, step_q);
	assign green_step = div_step(green_rem_q, count_q, step_q);
	assign blue_step  = div_step(blue_rem_q, count_q, step_q);

	assign red_quot_nx   = {red_quot_q[QUOT_W-2:0], red_step[SUM_W]};
	assign green_quot_nx = {green_quot_q[QUOT_W-2:0], green_step[SUM_W]};
	assign blue_quot_nx  = {blue_quot_q[QUOT_W-2:0], blue_step[SUM_W]};

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_color = color_q;
	assign out_error = out_error_q;

	// division payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			red_rem_q    <= in_data.red_total;
			green_rem_q  <= in_data.green_total;
			blue_rem_q   <= in_data.blue_total;
			count_q      <= in_data.count;
			error_q      <= in_data.stride_error;
			red_quot_q   <= '0;
			green_quot_q <= '0;
			blue_quot_q  <= '0;
		end else if (state_q == ST_DIV) begin
			red_rem_q    <= red_step[SUM_W-1:0];
			green_rem_q  <= green_step[SUM_W-1:0];
			blue_rem_q   <= blue_step[SUM_W-1:0];
			red_quot_q   <= red_quot_nx;
			green_quot_q <= green_quot_nx;
			blue_quot_q  <= blue_quot_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && (step_q == 3'd0)) begin
			out_error_q <= error_q;
			if (error_q || (count_q == '0)) begin
				color_q <= '0;
			end else begin
				color_q <= {red_quot_nx, green_quot_nx, blue_quot_nx};
			end
		end
	end

	// sequencer and output request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= ST_DIV;
						step_q  <= 3'd7;
					end
				end
				ST_DIV: begin
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/frame_average_color.sv -----
// top level: configuration registers and the front, queue and divider
//
// Pixels stream in at one per clock in raster order; the front sums blue, green and red over
// every pixel of each sampled row and counts them. On a frame's last pixel the sums move into
// a two-entry queue, and the divider turns them into the mean color, one quotient bit per cycle
// for all three channels. The sums pass from a queue entry into the divider registers and the
// mean into the result register, which holds it until it is taken. s_axis_tready drops only
// when the queue holds two unfinished frames, and after a row_stride write while the row
// position modulo the new stride is rebuilt one bit per cycle.
// Registers: frame_width at 0x0, frame_height at 0x4, row_stride at 0x8; a width or height of
// zero acts as 1, above 4096 as 4096, a stride of zero as 1.
module frame_average_color import fac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [PIX_W-1:0]  s_axis_tdata,   // blue 7:0, green 15:8, red 23:16
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [PIX_W-1:0]  m_axis_tdata,   // mean color 23:0
	output logic              m_axis_tuser    // stride_error
);

	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [STRIDE_W-1:0] stride_q;
	logic                cfg_wr;
	logic                stride_wr;
	fac_cfg_t            cfg;
	logic                q_in_valid;
	logic                q_in_ready;
	fac_frame_t          q_in_data;
	logic                q_out_valid;
	logic                q_out_ready;
	fac_frame_t          q_out_data;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign stride_wr = cfg_wr && (paddr[3:2] == REG_STRIDE);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			stride_q <= STRIDE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_STRIDE: stride_q <= pwdata[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = {19'b0, width_q};
			REG_HEIGHT: prdata = {19'b0, height_q};
			REG_STRIDE: prdata = {24'b0, stride_q};
			default:    prdata = '0;
		endcase
	end

	// effective geometry
	always_comb begin
		if (width_q == '0) begin
			cfg.width = 13'd1;
		end else if (width_q > MAX_DIM) begin
			cfg.width = MAX_DIM;
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = 13'd1;
		end else if (height_q > MAX_DIM) begin
			cfg.height = MAX_DIM;
		end else begin
			cfg.height = height_q;
		end
		cfg.stride = (stride_q == '0) ? 8'd1 : stride_q;
	end

	fac_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.stride_wr   (stride_wr),
		.pix_valid   (s_axis_tvalid),
		.pix_ready   (s_axis_tready),
		.pix_data    (s_axis_tdata),
		.frame_valid (q_in_valid),
		.frame_ready (q_in_ready),
		.frame       (q_in_data)
	);

	fac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_data   (q_in_data),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_data  (q_out_data)
	);

	fac_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_out_valid),
		.in_ready  (q_out_ready),
		.in_data   (q_out_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_color (m_axis_tdata),
		.out_error (m_axis_tuser)
	);

endmodule

// ----- dv/frame_average_color_checker.sv -----
// checker for the frame average color block: predicts each frame's mean color and compares
module frame_average_color_checker import fac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [PIX_W-1:0]  s_axis_tdata,   // blue 7:0, green 15:8, red 23:16
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [PIX_W-1:0]  m_axis_tdata,   // mean color 23:0
	input  logic              m_axis_tuser,   // stride_error
	output int unsigned       mismatches,
	output int unsigned       pending
);

	typedef struct packed {
		logic [PIX_W-1:0] color;
		logic             stride_error;
	} frame_mean_t;

	// register copies and frame state
	logic [DIM_W-1:0]    width_cfg;
	logic [DIM_W-1:0]    height_cfg;
	logic [STRIDE_W-1:0] stride_cfg;
	logic [POS_W-1:0]    col_pos;
	logic [POS_W-1:0]    row_pos;
	logic [SUM_W-1:0]    red_sum;
	logic [SUM_W-1:0]    green_sum;
	logic [SUM_W-1:0]    blue_sum;
	logic [CNT_W-1:0]    pixel_count;

	frame_mean_t colors_due[$];
	int unsigned fail_total;

	// track registers and pixels, predict each frame's result, check returned results
	always @(posedge clk or negedge arst_n) begin : mean_predictor
		int unsigned w, h, s, used_rows;
		logic row_end, frame_end;
		logic [SUM_W-1:0] red_mean, green_mean, blue_mean;
		frame_mean_t want, got;
		if (!arst_n) begin
			width_cfg = WIDTH_RST;
			height_cfg = HEIGHT_RST;
			stride_cfg = STRIDE_RST;
			col_pos = '0;
			row_pos = '0;
			red_sum = '0;
			green_sum = '0;
			blue_sum = '0;
			pixel_count = '0;
			colors_due.delete();
			fail_total = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			// result request against the oldest waiting frame
			if (m_axis_tvalid && m_axis_tready) begin
				got.color = m_axis_tdata;
				got.stride_error = m_axis_tuser;
				if (colors_due.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("[%0t] unexpected result: color %h stride error %b",
							$realtime, got.color, got.stride_error);
				end else begin
					want = colors_due.pop_front();
					if (got != want) begin
						fail_total++;
						if (fail_total <= 10)
							$display("[%0t] mean mismatch: expected color %h err %b, got color %h err %b",
								$realtime, want.color, want.stride_error, got.color,
								got.stride_error);
					end
				end
			end

			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_WIDTH:  width_cfg = pwdata[DIM_W-1:0];
					REG_HEIGHT: height_cfg = pwdata[DIM_W-1:0];
					REG_STRIDE: stride_cfg = pwdata[STRIDE_W-1:0];
					default: ;
				endcase
			end

			// pixel request: sample, advance position, close the frame
			if (s_axis_tvalid && s_axis_tready) begin
				w = (width_cfg == '0) ? 1 : (width_cfg > MAX_DIM) ? MAX_DIM : width_cfg;
				h = (height_cfg == '0) ? 1 : (height_cfg > MAX_DIM) ? MAX_DIM : height_cfg;
				s = (stride_cfg == '0) ? 1 : stride_cfg;
				used_rows = (h / s) * s;

				if ((row_pos % s) == 0 && row_pos < used_rows) begin
					blue_sum += s_axis_tdata[7:0];
					green_sum += s_axis_tdata[15:8];
					red_sum += s_axis_tdata[23:16];
					pixel_count += 1'b1;
				end

				row_end = col_pos >= w - 1;
				frame_end = row_end && row_pos >= h - 1;

				if (!frame_end) begin
					if (row_end) begin
						col_pos = '0;
						row_pos++;
					end else begin
						col_pos++;
					end
				end else begin
					// stride above height flags an error, an empty sample gives black
					want.color = '0;
					want.stride_error = 1'b0;
					if (s > h) begin
						want.stride_error = 1'b1;
					end else if (pixel_count != '0) begin
						red_mean = red_sum / pixel_count;
						green_mean = green_sum / pixel_count;
						blue_mean = blue_sum / pixel_count;
						want.color = {red_mean[7:0], green_mean[7:0], blue_mean[7:0]};
					end
					colors_due.push_back(want);
					col_pos = '0;
					row_pos = '0;
					red_sum = '0;
					green_sum = '0;
					blue_sum = '0;
					pixel_count = '0;
				end
			end

			pending <= colors_due.size();
			mismatches <= fail_total;
		end
	end

endmodule

// ----- dv/frame_average_color_tb.sv -----
// testbench top for the frame average color block: stimulus, bus stalls and verdict
module frame_average_color_tb;
	import fac_pkg::*;

	localparam int unsigned PIXEL_GOAL     = 1550;
	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned DRAIN_CYCLES   = 32;
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [PIX_W-1:0]  s_axis_tdata = '0;   // blue 7:0, green 15:8, red 23:16
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [PIX_W-1:0]  m_axis_tdata;        // mean color 23:0
	logic              m_axis_tuser;        // stride_error

	int unsigned mismatches;
	int unsigned pending;
	int unsigned burst_left = 0;
	int unsigned pixels_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned ready_phase = 0;
	int unsigned stall_mode = 0;

	frame_average_color uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	frame_average_color_checker mean_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.mismatches(mismatches), .pending(pending)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side stalls: always ready, random or periodic patterns, picked at random
	always @(posedge clk) begin
		ready_phase <= ready_phase + 1;
		if (ready_phase % 256 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (ready_phase % 5 == 0);
			default: m_axis_tready <= (ready_phase % 64 >= 40);
		endcase
	end

	// watchdog on cycles with no request moving anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// effective size of a width or height register value
	function automatic int unsigned dim_used(input int unsigned raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_DIM)
			return MAX_DIM;
		return raw;
	endfunction

	// mostly tiny dimensions, sometimes zero or a bit larger
	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(9, 40);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	// pixel content with the channel extremes mixed in
	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 15))
			0: return {PIX_W{1'b1}};
			1: return '0;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic pause_stream();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// one pixel request; bursts of random length separated by gaps
	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
			                                          : $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		pixels_sent++;
	endtask

	// stop pixels, wait for every pending result, then let the divider go quiet
	task automatic drain_results();
		pause_stream();
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, access cycle, then back to idle
	task automatic write_reg(input logic [1:0] index, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h,
	                            input int unsigned s);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_STRIDE, s);
	endtask

	// stimulus
	initial begin
		int unsigned cur_w, cur_h, cur_s, hu, frame_pixels, n, goal;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 frames every row sampled: channel extremes then all white
		set_geometry(2, 2, 1);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h123456);
		send_pixel(24'hEDCBA9);
		repeat (4) send_pixel(24'hFFFFFF);

		// stride above height gives the error flag
		drain_results();
		set_geometry(3, 1, 2);
		repeat (3) send_pixel(pick_pixel());

		// zero width, height and stride act as one: single pixel frames
		drain_results();
		set_geometry(0, 0, 0);
		send_pixel(24'hA5C3F0);
		send_pixel(24'h5A3C0F);

		// stride change mid-frame leaves no sampled pixel: black, no error
		drain_results();
		set_geometry(2, 4, 8);
		repeat (2) send_pixel(pick_pixel());
		drain_results();
		write_reg(REG_STRIDE, 3);
		repeat (6) send_pixel(pick_pixel());

		// width shrunk mid-row ends the row on the next pixel
		drain_results();
		set_geometry(8, 2, 1);
		repeat (5) send_pixel(pick_pixel());
		drain_results();
		write_reg(REG_WIDTH, 3);
		repeat (4) send_pixel(pick_pixel());

		// oversized height, then cut down mid-frame
		drain_results();
		set_geometry(1, 8191, 1);
		repeat (10) send_pixel(pick_pixel());
		drain_results();
		write_reg(REG_HEIGHT, 12);
		repeat (2) send_pixel(pick_pixel());

		// oversized width clamps to 4096, not to its low bits: no row end early,
		// then a narrow width closes the row on the next pixel
		drain_results();
		set_geometry(4200, 1, 1);
		repeat (150) send_pixel(pick_pixel());
		drain_results();
		write_reg(REG_WIDTH, 3);
		send_pixel(pick_pixel());

		// random geometry phases, mostly whole frames
		cur_w = 3;
		cur_h = 1;
		cur_s = 1;
		goal = pixels_sent + PIXEL_GOAL;
		while (pixels_sent < goal) begin
			drain_results();
			if ($urandom_range(0, 19) == 0) begin
				// tall narrow frame with the largest stride
				cur_w = 1;
				cur_h = $urandom_range(255, 300);
				cur_s = 255;
				set_geometry(cur_w, cur_h, cur_s);
			end else begin
				if (dim_used(cur_w) > 64 || $urandom_range(0, 2) != 0) begin
					cur_w = pick_dim();
					write_reg(REG_WIDTH, cur_w);
				end
				if ($urandom_range(0, 2) != 0) begin
					cur_h = pick_dim();
					write_reg(REG_HEIGHT, cur_h);
				end
				if ($urandom_range(0, 2) != 0) begin
					hu = dim_used(cur_h);
					case ($urandom_range(0, 9))
						0: cur_s = 0;
						1: cur_s = 255;
						2: cur_s = $urandom_range(hu + 1, hu + 3);
						default: cur_s = $urandom_range(1, hu);
					endcase
					write_reg(REG_STRIDE, cur_s);
				end
			end

			frame_pixels = dim_used(cur_w) * dim_used(cur_h);
			n = frame_pixels * ((frame_pixels > 200) ? 1 : $urandom_range(1, 4));
			// sometimes stop mid-frame so the next phase changes sizes under it
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(1, frame_pixels);
			// keep the total pixel count near the goal
			if (n > goal - pixels_sent)
				n = goal - pixels_sent;

			repeat (n) begin
				if ($urandom_range(0, 199) == 0 || pixels_sent == goal - PIXEL_GOAL / 2) begin
					pause_stream();
					do @(posedge clk); while (pending != 0);
				end
				send_pixel(pick_pixel());
			end
		end

		// wait out the last results
		pause_stream();
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/fac_pkg.sv
rtl/fac_front.sv
rtl/fac_queue.sv
rtl/fac_divider.sv
rtl/frame_average_color.sv
dv/frame_average_color_checker.sv
dv/frame_average_color_tb.sv
